// File: design/erc_pkg.sv
// Shared types and constants for the exercise repetition classifier.
`default_nettype none
package erc_pkg;

	localparam int unsigned ACCEL_W    = 16;
	localparam int unsigned CNT_W      = 8;
	localparam int unsigned WINDOW_DEF = 15;

	// Z scale and Q16 cosines of the tilt limits
	localparam longint COUNTS_PER_G = 17694;
	localparam longint COS140_Q16   = -50203;
	localparam longint COS30_Q16    = 56756;
	localparam longint COS80_Q16    = 11380;
	localparam longint COS35_Q16    = 53684;

	// raw sample limits
	localparam logic signed [ACCEL_W-1:0] Y_PUSH_MIN  = -16'sd7500;
	localparam logic signed [ACCEL_W-1:0] Z_PUSH_MAX  = -16'sd5000;
	localparam logic signed [ACCEL_W-1:0] Z_LIE_MIN   = 16'sd13000;
	localparam logic signed [ACCEL_W-1:0] Y_LIE_MIN   = -16'sd4000;
	localparam logic signed [ACCEL_W-1:0] Y_STAND_MAX = -16'sd16000;
	localparam logic signed [ACCEL_W-1:0] Y_UP_MAX    = -16'sd6500;
	localparam logic signed [ACCEL_W-1:0] Y_JUMP_MAX  = -16'sd25000;
	localparam logic signed [ACCEL_W-1:0] Z_SQUAT_MAX = -16'sd12500;

	localparam logic [CNT_W-1:0] CNT_RESET = 8'd15;

	typedef enum logic [2:0] {
		PH_WAITING   = 3'd0,
		PH_LYING     = 3'd1,
		PH_SITTING   = 3'd2,
		PH_PUSHING   = 3'd3,
		PH_UP        = 3'd4,
		PH_STANDING  = 3'd5,
		PH_JUMPING   = 3'd6,
		PH_SQUATTING = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		REG_SITUP_TARGET  = 2'd0,
		REG_PUSHUP_TARGET = 2'd1,
		REG_JUMP_TARGET   = 2'd2,
		REG_SQUAT_TARGET  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_y;
		logic signed [ACCEL_W-1:0] accel_z;
	} in_item_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] situps_left;
		logic [CNT_W-1:0] pushups_left;
		logic [CNT_W-1:0] jumps_left;
		logic [CNT_W-1:0] squats_left;
		logic [3:0]       done_mask;
		logic             all_done;
	} out_item_t;

endpackage
`default_nettype wire

// File: design/erc_window.sv
// Z sample shift line with running window sum.
`default_nettype none
module erc_window #(
	parameter int unsigned WINDOW = 15,
	parameter int unsigned SUM_W  = 20
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic signed [erc_pkg::ACCEL_W-1:0]    z,
	output logic signed [SUM_W-1:0]                    sum_nxt
);
	import erc_pkg::*;

	logic signed [ACCEL_W-1:0] taps_q [WINDOW];
	logic signed [SUM_W-1:0]   sum_q;

	// oldest sample drops out at the end of the line
	assign sum_nxt = sum_q - SUM_W'(taps_q[WINDOW-1]) + SUM_W'(z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				taps_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (en) begin
			taps_q[0] <= z;
			for (int i = 1; i < WINDOW; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
			sum_q <= sum_nxt;
		end
	end

endmodule
`default_nettype wire

// File: design/exercise_rep_classifier.sv
// Exercise repetition classifier: top level with phase FSM and rep counters.
// The input register and the result register lie between input transfer and
// result transfer. Throughput: 1 item per cycle unless out_ready stalls;
// the window sum, tilt compares and FSM settle in the single stage between
// the input register and the result register.
// Reset: window and sum cleared, phase waiting, all four counts 15.
// Once all counts reach zero, samples still give results but leave window, phase and counts alone.
`default_nettype none
module exercise_rep_classifier #(
	parameter int unsigned WINDOW = erc_pkg::WINDOW_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration writes, index = target register
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [erc_pkg::CNT_W-1:0]     cfg_data,
	// sample channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire erc_pkg::in_item_t             in_data,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output erc_pkg::out_item_t                 out_data
);
	import erc_pkg::*;

	localparam int unsigned SUM_W = ACCEL_W + $clog2(WINDOW);

	// "angle over A" is sum*65536 < cosA*W*g, i.e. sum < ceil(cosA*W*g/65536).
	// "angle under 30" is sum > floor(cos30*W*g/65536).
	// SV division truncates toward zero: ceil for negatives, floor for positives.
	localparam longint P140 = COS140_Q16 * longint'(WINDOW) * COUNTS_PER_G;
	localparam longint P80  = COS80_Q16 * longint'(WINDOW) * COUNTS_PER_G;
	localparam longint P35  = COS35_Q16 * longint'(WINDOW) * COUNTS_PER_G;
	localparam longint P30  = COS30_Q16 * longint'(WINDOW) * COUNTS_PER_G;
	localparam longint C140 = (P140 > 0) ? ((P140 + 65535) / 65536) : (P140 / 65536);
	localparam longint C80  = (P80 > 0) ? ((P80 + 65535) / 65536) : (P80 / 65536);
	localparam longint C35  = (P35 > 0) ? ((P35 + 65535) / 65536) : (P35 / 65536);
	localparam longint F30  = (P30 >= 0) ? (P30 / 65536) : ((P30 - 65535) / 65536);
	localparam logic signed [SUM_W-1:0] THR_140 = SUM_W'(C140);
	localparam logic signed [SUM_W-1:0] THR_80  = SUM_W'(C80);
	localparam logic signed [SUM_W-1:0] THR_35  = SUM_W'(C35);
	localparam logic signed [SUM_W-1:0] THR_30  = SUM_W'(F30);

	// handshake and stage registers
	logic       valid_s1;
	in_item_t   item_s1;
	logic       out_valid_q;
	out_item_t  out_data_q;
	logic       advance;

	// architectural state
	phase_t           phase_q;
	logic [CNT_W-1:0] cnt_q [4];

	// stage logic
	logic                    frozen;
	logic signed [SUM_W-1:0] sum_nxt;
	logic                    over140, over80, over35, under30, lying_pose;
	phase_t                  phase_nxt, phase_upd;
	logic [3:0]              dec;
	logic [CNT_W-1:0]        cnt_upd [4];
	logic [3:0]              mask_upd;

	// the stage moves whenever the result register is free or being drained
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign frozen = (cnt_q[0] == '0) && (cnt_q[1] == '0) &&
		(cnt_q[2] == '0) && (cnt_q[3] == '0);

	erc_window #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance && !frozen),
		.z       (item_s1.accel_z),
		.sum_nxt (sum_nxt)
	);

	// tilt tests on the updated window sum
	assign over140    = sum_nxt < THR_140;
	assign over80     = sum_nxt < THR_80;
	assign over35     = sum_nxt < THR_35;
	assign under30    = sum_nxt > THR_30;
	assign lying_pose = (item_s1.accel_z > Z_LIE_MIN) && (item_s1.accel_y > Y_LIE_MIN) &&
		under30;

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_WAITING: begin
				if ((item_s1.accel_y > Y_PUSH_MIN) && (item_s1.accel_z < Z_PUSH_MAX) &&
						over140) begin
					phase_nxt = PH_PUSHING;
				end else if (lying_pose) begin
					phase_nxt = PH_LYING;
				end else if ((item_s1.accel_y < Y_STAND_MAX) && over80) begin
					phase_nxt = PH_STANDING;
				end
			end
			PH_LYING: begin
				if (over35) begin
					phase_nxt = PH_SITTING;
				end
			end
			PH_PUSHING: begin
				if (item_s1.accel_y < Y_UP_MAX) begin
					phase_nxt = PH_UP;
				end
			end
			PH_STANDING: begin
				if (lying_pose) begin
					phase_nxt = PH_LYING;
				end else if (over140) begin
					phase_nxt = PH_PUSHING;
				end else if (item_s1.accel_y < Y_JUMP_MAX) begin
					phase_nxt = PH_JUMPING;
				end else if (item_s1.accel_z < Z_SQUAT_MAX) begin
					phase_nxt = PH_SQUATTING;
				end
			end
			PH_SITTING, PH_UP, PH_JUMPING, PH_SQUATTING: begin
				phase_nxt = PH_WAITING;
			end
			default: begin
				phase_nxt = PH_WAITING;
			end
		endcase
	end

	// a completed rep is counted on leaving its end phase
	always_comb begin
		dec = '0;
		case (phase_q)
			PH_SITTING:   dec[0] = 1'b1;
			PH_UP:        dec[1] = 1'b1;
			PH_JUMPING:   dec[2] = 1'b1;
			PH_SQUATTING: dec[3] = 1'b1;
			default:      dec = '0;
		endcase
	end

	// frozen items leave state alone; counts saturate at zero
	always_comb begin
		phase_upd = frozen ? phase_q : phase_nxt;
		for (int k = 0; k < 4; k++) begin
			cnt_upd[k] = cnt_q[k];
			if (!frozen && dec[k] && (cnt_q[k] != '0)) begin
				cnt_upd[k] = cnt_q[k] - CNT_W'(1);
			end
			mask_upd[k] = (cnt_upd[k] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_WAITING;
			for (int k = 0; k < 4; k++) begin
				cnt_q[k] <= CNT_RESET;
			end
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				phase_q <= phase_upd;
			end
			// target writes reload the count; the user must let them come only while idle, as the block has no guard
			if (cfg_we) begin
				cnt_q[cfg_index] <= cfg_data;
			end else if (advance) begin
				for (int k = 0; k < 4; k++) begin
					cnt_q[k] <= cnt_upd[k];
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data_q.phase        <= phase_upd;
			out_data_q.situps_left  <= cnt_upd[REG_SITUP_TARGET];
			out_data_q.pushups_left <= cnt_upd[REG_PUSHUP_TARGET];
			out_data_q.jumps_left   <= cnt_upd[REG_JUMP_TARGET];
			out_data_q.squats_left  <= cnt_upd[REG_SQUAT_TARGET];
			out_data_q.done_mask    <= mask_upd;
			out_data_q.all_done     <= &mask_upd;
		end
	end

endmodule
`default_nettype wire
